// ----- hdl/b2d_pkg.sv -----
// Shared constants, types and state encoding for the binary to decimal ASCII unit.
// No dependencies.
`default_nettype none

package b2d_pkg;

  localparam int unsigned NumDigits   = 10;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned CharWidth   = 6;
  localparam int unsigned BitCntWidth = $clog2(ValueWidth);
  localparam int unsigned RemWidth    = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0]  AsciiZero   = CharWidth'(48);
  localparam logic [DigitWidth-1:0] DabbleLimit = DigitWidth'(5);
  localparam logic [DigitWidth-1:0] DabbleAdd   = DigitWidth'(3);
  localparam logic [DigitWidth-1:0] DigitMax    = DigitWidth'(9);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } b2d_state_e;

  // Control word broadcast to every digit cell.
  typedef struct packed {
    logic clr;     // zero the digit
    logic dabble;  // add-3 correction, then shift in the neighbour's carry
    logic rotate;  // take the lower neighbour's digit
  } b2d_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/b2d_if.sv -----
// Valid/ready channel interfaces for the binary to decimal ASCII unit.
// Depends on b2d_pkg.
`default_nettype none

interface b2d_in_if import b2d_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2d_out_if import b2d_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] digit_char;
  logic                 last_char;

  modport source (output valid, output digit_char, output last_char, input ready);
  modport sink   (input valid, input digit_char, input last_char, output ready);
endinterface

`default_nettype wire

// ----- hdl/b2d_digit_cell.sv -----
// One BCD digit cell of the conversion chain: double-dabble step or digit rotation.
// Depends on b2d_pkg.
`default_nettype none

module b2d_digit_cell import b2d_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire b2d_cell_ctrl_t        ctrl_i,
  input  wire logic                  carry_i,
  input  wire logic [DigitWidth-1:0] digit_i,
  output logic                       carry_o,
  output logic [DigitWidth-1:0]      digit_o
);

  logic [DigitWidth-1:0] digit_q, digit_d;
  logic [DigitWidth-1:0] adj;

  // Correct a digit of five or more before the shift so it carries out cleanly.
  assign adj     = (digit_q >= DabbleLimit) ? digit_q + DabbleAdd : digit_q;
  assign carry_o = adj[DigitWidth-1];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[DigitWidth-2:0], carry_i};
    end else if (ctrl_i.rotate) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/binary_to_decimal_ascii_unit.sv -----
// Binary to decimal ASCII unit: 32-bit value in, decimal digit characters out, MSD first.
// Conversion: double-dabble as a one-bit-a-cycle shift through a row of ten digit cells, then
// up to nine leading zeros are dropped and each remaining digit is registered as a character.
// A new value is accepted only while idle, after the previous one's last character has been
// registered; a sink that is not ready holds emission. Reset is asynchronous and clears the
// control state and the digit cells.
`default_nettype none

module binary_to_decimal_ascii_unit import b2d_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  b2d_in_if.sink        in_i,
  b2d_out_if.source     out_o
);

  // Control state.
  b2d_state_e            state_q, state_d;
  logic [BitCntWidth-1:0] bit_cnt_q, bit_cnt_d;
  logic [RemWidth-1:0]    rem_q, rem_d;       // digits left in the chain
  logic                   started_q, started_d; // a non-zero digit has been seen
  logic                   out_valid_q, out_valid_d;

  // Payload.
  logic [ValueWidth-1:0] value_q, value_d;
  logic [CharWidth-1:0]  char_q, char_d;
  logic                  last_q, last_d;

  // Cell chain.
  b2d_cell_ctrl_t        cell_ctrl;
  logic [NumDigits:0]    carry;
  logic [DigitWidth-1:0] digit [NumDigits];
  logic [DigitWidth-1:0] top_digit;

  logic in_fire;
  logic out_free;
  logic conv_done;
  logic skip;
  logic emit_fire;

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign conv_done = (state_q == ST_CONV) && (bit_cnt_q == BitCntWidth'(ValueWidth - 1));
  assign top_digit = digit[NumDigits-1];

  // Drop a leading zero, but always keep the last digit so zero prints as '0'.
  assign skip      = (state_q == ST_EMIT) && !started_q && (top_digit == '0)
                     && (rem_q != RemWidth'(1));
  assign emit_fire = (state_q == ST_EMIT) && !skip && out_free;

  // The binary word enters the chain MSB first at the least significant cell; each cell
  // passes its carry to the next more significant cell. During emission digits rotate
  // upwards so the most significant remaining digit always sits in the top cell.
  assign carry[0] = value_q[ValueWidth-1];

  for (genvar g = 0; g < NumDigits; g++) begin : g_cell
    logic [DigitWidth-1:0] digit_in;
    if (g == 0) begin : g_first
      assign digit_in = '0;
    end else begin : g_rest
      assign digit_in = digit[g-1];
    end

    b2d_digit_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .carry_i (carry[g]),
      .digit_i (digit_in),
      .carry_o (carry[g+1]),
      .digit_o (digit[g])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire && (rem_q == RemWidth'(1))) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    cell_ctrl   = '0;
    value_d     = value_q;
    bit_cnt_d   = bit_cnt_q;
    rem_d       = rem_q;
    started_d   = started_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          value_d       = in_i.value;
          bit_cnt_d     = '0;
          cell_ctrl.clr = 1'b1;
        end
      end
      ST_CONV: begin
        cell_ctrl.dabble = 1'b1;
        value_d          = {value_q[ValueWidth-2:0], 1'b0};
        bit_cnt_d        = bit_cnt_q + BitCntWidth'(1);
        if (conv_done) begin
          rem_d     = RemWidth'(NumDigits);
          started_d = 1'b0;
        end
      end
      ST_EMIT: begin
        if (skip || emit_fire) begin
          cell_ctrl.rotate = 1'b1;
          rem_d            = rem_q - RemWidth'(1);
        end
        if (emit_fire) begin
          started_d   = 1'b1;
          out_valid_d = 1'b1;
          char_d      = AsciiZero + CharWidth'(top_digit);
          last_d      = (rem_q == RemWidth'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      rem_q       <= rem_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = char_q;
  assign out_o.last_char  = last_q;

  // Checks.
  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_CONV))
    else $error("accepted word did not start a conversion");

  a_top_digit_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (top_digit <= DigitMax))
    else $error("top cell holds a non-decimal digit");

  a_emit_has_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (rem_q != '0))
    else $error("emitting with no digits left");

  a_first_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && !started_q && (rem_q != RemWidth'(1))) |-> (top_digit != '0))
    else $error("leading zero emitted");

endmodule

`default_nettype wire
